>>> src/bddc_pkg.sv
package bddc_pkg;

	localparam logic [7:0] FLAG_PATTERN_RST     = 8'd126;
	localparam logic [2:0] CRC_POLY_LOW_RST     = 3'd3;
	localparam logic [2:0] STUFF_RUN_LENGTH_RST = 3'd5;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_FLAG_PATTERN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY_LOW     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STUFF_RUN_LENGTH = 2'd2;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// bits since flag saturate here; the tail delay is full from this count on
	localparam logic [3:0] BSF_SAT      = 4'd12;
	localparam logic [3:0] BSF_WINDOW   = 4'd8;
	localparam logic [3:0] BSF_IN_FRAME = 4'd9;

	localparam int BUF_DEPTH = 4;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);

	typedef struct packed {
		logic [7:0] flag_pattern;
		logic [2:0] crc_poly_low;
		logic [2:0] stuff_run_length;
	} cfg_t;

	typedef struct packed {
		logic kind;
		logic bit_val;
		logic ok;
		logic last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} step_out_t;

endpackage

>>> src/bddc_core.sv
module bddc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               rx_bit,
	input  bddc_pkg::cfg_t     cfg,
	output bddc_pkg::step_out_t step
);

	logic [7:0] win_q;
	logic       in_frame_q;
	logic [3:0] bsf_q;
	logic [2:0] rem_q;
	logic [2:0] tail_q;
	logic [2:0] ones_q;
	logic       drop_q;

	logic [7:0] win_n;
	logic       in_frame_n;
	logic [3:0] bsf_n;
	logic [2:0] rem_n;
	logic [2:0] tail_n;
	logic [2:0] ones_n;
	logic       drop_n;

	logic [3:0] cnt;
	logic       leaving;
	logic       active;
	logic       full;
	logic       pay_emit;
	logic [2:0] run1;
	logic       hit;
	logic       flag;
	logic       verdict;
	logic       ok;
	logic [2:0] rem_upd;

	always_comb begin
		leaving = win_q[7];
		win_n   = {win_q[6:0], rx_bit};
		cnt     = (bsf_q >= bddc_pkg::BSF_SAT) ? bddc_pkg::BSF_SAT : bsf_q + 4'd1;
		active  = in_frame_q && (cnt >= bddc_pkg::BSF_IN_FRAME);
		full    = cnt >= bddc_pkg::BSF_SAT;
		pay_emit = active && full && !drop_q;

		run1 = tail_q[2] ? ones_q + 3'd1 : 3'd0;
		hit  = (cfg.stuff_run_length != 3'd0) && (run1 == cfg.stuff_run_length);

		rem_upd = {rem_q[1:0], leaving} ^ (rem_q[2] ? cfg.crc_poly_low : 3'd0);

		in_frame_n = in_frame_q;
		bsf_n      = cnt;
		rem_n      = rem_q;
		tail_n     = tail_q;
		ones_n     = ones_q;
		drop_n     = drop_q;

		if (active) begin
			rem_n  = rem_upd;
			tail_n = {tail_q[1:0], leaving};
			if (full) begin
				if (drop_q) begin
					drop_n = 1'b0;
				end else begin
					ones_n = hit ? 3'd0 : run1;
					drop_n = hit;
				end
			end
		end

		flag    = (cnt >= bddc_pkg::BSF_WINDOW) && (win_n == cfg.flag_pattern);
		verdict = flag && active;
		ok      = full && (rem_n == 3'd0);

		if (flag) begin
			in_frame_n = 1'b1;
			bsf_n      = 4'd0;
			rem_n      = 3'd0;
			tail_n     = 3'd0;
			ones_n     = 3'd0;
			drop_n     = 1'b0;
		end
	end

	// payload bit goes first when both results come from one bit
	always_comb begin
		step.count = {1'b0, pay_emit} + {1'b0, verdict};
		step.r1    = '{kind: bddc_pkg::KIND_VERDICT, bit_val: 1'b0, ok: ok, last: 1'b1};
		if (pay_emit) begin
			step.r0 = '{kind: bddc_pkg::KIND_PAYLOAD, bit_val: tail_q[2], ok: 1'b0,
				last: !verdict};
		end else begin
			step.r0 = step.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			in_frame_q <= 1'b0;
			bsf_q      <= '0;
			rem_q      <= '0;
			tail_q     <= '0;
			ones_q     <= '0;
			drop_q     <= 1'b0;
		end else if (accept) begin
			win_q      <= win_n;
			in_frame_q <= in_frame_n;
			bsf_q      <= bsf_n;
			rem_q      <= rem_n;
			tail_q     <= tail_n;
			ones_q     <= ones_n;
			drop_q     <= drop_n;
		end
	end

endmodule

>>> src/bit_deframer_destuff_crc_check_unit.sv
// a result is registered into the buffer when the bit that causes it is accepted, and is offered from there
// throughput: one line bit per cycle while in_stall is low; a bit gives zero, one or two results
// results wait in a four-entry buffer; the input stalls while it holds more than two
// output rate is one result per cycle while out_stall is low, set by the buffer read port
// reset (arst_n, asynchronous): frame state cleared, registers to defaults, buffer empty
module bit_deframer_destuff_crc_check_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              rx_bit,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              out_kind,
	output logic                              payload_bit,
	output logic                              crc_ok,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bddc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bddc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	bddc_pkg::cfg_t      cfg_q;
	bddc_pkg::step_out_t step;
	bddc_pkg::result_t   buf_q [bddc_pkg::BUF_DEPTH];

	logic [bddc_pkg::BUF_AW-1:0] wr_q;
	logic [bddc_pkg::BUF_AW-1:0] rd_q;
	logic [bddc_pkg::BUF_AW:0]   fill_q;
	logic                        accept;
	logic                        pop;
	logic [1:0]                  push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_pattern     <= bddc_pkg::FLAG_PATTERN_RST;
			cfg_q.crc_poly_low     <= bddc_pkg::CRC_POLY_LOW_RST;
			cfg_q.stuff_run_length <= bddc_pkg::STUFF_RUN_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bddc_pkg::CFG_FLAG_PATTERN:     cfg_q.flag_pattern     <= cfg_data;
				bddc_pkg::CFG_CRC_POLY_LOW:     cfg_q.crc_poly_low     <= cfg_data[2:0];
				bddc_pkg::CFG_STUFF_RUN_LENGTH: cfg_q.stuff_run_length <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// room for two results must exist before a bit is taken
	assign in_stall  = fill_q > (bddc_pkg::BUF_AW + 1)'(bddc_pkg::BUF_DEPTH - 2);
	assign accept    = in_valid && !in_stall;
	assign out_valid = fill_q != '0;
	assign pop       = out_valid && !out_stall;
	assign push      = accept ? step.count : 2'd0;

	bddc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.rx_bit (rx_bit),
		.cfg    (cfg_q),
		.step   (step)
	);

	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			buf_q[wr_q] <= step.r0;
		end
		if (push == 2'd2) begin
			buf_q[wr_q + bddc_pkg::BUF_AW'(1)] <= step.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_q + bddc_pkg::BUF_AW'(push);
			rd_q   <= rd_q + bddc_pkg::BUF_AW'(pop);
			fill_q <= fill_q + (bddc_pkg::BUF_AW + 1)'(push)
				- (bddc_pkg::BUF_AW + 1)'(pop);
		end
	end

	assign out_kind    = buf_q[rd_q].kind;
	assign payload_bit = buf_q[rd_q].bit_val;
	assign crc_ok      = buf_q[rd_q].ok;
	assign last        = buf_q[rd_q].last;

endmodule

>>> src/bddc_checker.sv
module bddc_assertions (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic out_kind,
	input logic payload_bit,
	input logic crc_ok,
	input logic last
);

	// a stalled transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output transaction withdrawn under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({out_kind, payload_bit, crc_ok, last}))
		else $error("stalled output payload changed");

	// a verdict always closes the results of its bit
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == bddc_pkg::KIND_VERDICT) |-> last && !payload_bit)
		else $error("verdict not final or carries a payload bit");

	a_payload_no_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == bddc_pkg::KIND_PAYLOAD) |-> !crc_ok)
		else $error("payload transaction flags crc_ok");

endmodule

bind bit_deframer_destuff_crc_check_unit bddc_assertions u_bddc_assertions (.*);
